>>> sv/mabs_pkg.sv
// ----------------------------------------------------------------------------
// mabs_pkg: shared types and constants for the trailing band block
// Holds the sequencer states, the register map, the divider control struct and the fixed field widths.
// ----------------------------------------------------------------------------
package mabs_pkg;

    localparam int PRICE_W = 32;
    localparam int SUM_W   = 40;
    localparam int STRIP_W = 16;
    localparam int WDAY_W  = 9;

    // register indexes
    localparam logic [0:0] REG_WINDOW = 1'd0;
    localparam logic [0:0] REG_STRIP  = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_MUL_UP,
        ST_MUL_DN,
        ST_DECIDE,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

>>> sv/moving_average_band_signal.sv
// ----------------------------------------------------------------------------
// moving_average_band_signal: per-series moving average trailing band
// Keeps window sums and price rings per series; returns reference and mode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_series_index, i_close_price
//  output  | out       | o_valid / i_stall  | o_series_echo, o_reference_level,
//          |           |                    | o_sold_mode
//  config  | in        | APB write/read     | window_days, strip_fraction
//
// Once the window is full, an accepted input beat passes ring read, sum,
// the divide (the 40-bit restoring divider runs one quotient bit per cycle),
// two band multiplies, decide and write-back before o_valid rises. While the
// window fills there is no divide and only the lower band multiply runs, on
// the close price.
// One beat is in flight at a time; o_stall is high from accept until the
// result beat leaves, so the input takes no new beat before then. Reset
// clears all per-series state at once (valid flags on the small stores); the
// ring memory is not cleared.
// A stalled result holds on the output registers.
// ----------------------------------------------------------------------------
module moving_average_band_signal
    import mabs_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int NUM_SERIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [5:0]           i_series_index,
    input  logic [PRICE_W-1:0]   i_close_price,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [5:0]           o_series_echo,
    output logic [PRICE_W-1:0]   o_reference_level,
    output logic                 o_sold_mode,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SER_W  = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
    localparam int SLOT_W = SER_W + POS_W;
    localparam int RING_D = 1 << SLOT_W;

    // configuration registers
    logic [WDAY_W-1:0]  r_window;
    logic [STRIP_W-1:0] r_strip;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WDAY_W'(20);
            r_strip  <= STRIP_W'(3277);
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            case (paddr[2])
                REG_WINDOW: r_window <= pwdata[WDAY_W-1:0];
                REG_STRIP:  r_strip  <= pwdata[STRIP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW: prdata = 32'(r_window);
            REG_STRIP:  prdata = 32'(r_strip);
            default:    prdata = '0;
        endcase
    end

    // effective window
    logic [WDAY_W+3:0] w_win;
    always_comb begin
        if (r_window == '0) begin
            w_win = 13'd1;
        end else if (13'(r_window) > 13'(MAX_WINDOW)) begin
            w_win = 13'(MAX_WINDOW);
        end else begin
            w_win = 13'(r_window);
        end
    end

    // per-series state; cleared by valid flags
    logic [NUM_SERIES-1:0]  r_vld;
    logic [CNT_W-1:0]       r_cnt_m [NUM_SERIES];
    logic [SUM_W-1:0]       r_sum_m [NUM_SERIES];
    logic [PRICE_W-1:0]     r_ref_m [NUM_SERIES];
    logic                   r_sold_m[NUM_SERIES];
    logic [POS_W-1:0]       r_pos_m [NUM_SERIES];
    logic [PRICE_W-1:0]     r_ring  [RING_D];

    t_state r_state, n_state;

    logic [SER_W-1:0]   r_ser;
    logic [5:0]         r_ser6;
    logic [PRICE_W-1:0] r_price;
    logic [CNT_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_sum;
    logic [PRICE_W-1:0] r_ref;
    logic               r_sold;
    logic [POS_W:0]     r_pos;
    logic [PRICE_W-1:0] r_old;
    logic [SUM_W-1:0]   r_avg;
    logic [PRICE_W-1:0] r_up;
    logic [PRICE_W-1:0] r_dn;
    logic               r_ovld;
    logic [PRICE_W-1:0] r_oref;
    logic               r_osold;
    logic [5:0]         r_oser;

    logic               w_acc;
    logic               w_fill;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_quo;
    t_div_ctl           w_dctl;
    logic [SLOT_W-1:0]  w_slot;
    logic [SUM_W-1:0]   w_nsum;

    assign o_stall = (r_state != ST_IDLE) || r_ovld;
    assign w_acc   = i_valid && !o_stall;
    assign w_fill  = 13'(r_n) < w_win;
    assign w_slot  = {r_ser, r_pos[POS_W-1:0]};

    // updated window sum: add newest, drop oldest once full
    assign w_nsum  = w_fill ? (r_sum + SUM_W'(r_price))
                            : (r_sum + SUM_W'(r_price) - SUM_W'(r_old));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_acc && 32'(i_series_index) < 32'(NUM_SERIES)) begin
                           n_state = ST_READ;
                       end
            ST_READ:   n_state = ST_SUM;
            ST_SUM:    n_state = w_fill ? ST_MUL_DN : ST_DIV;
            ST_DIV:    if (w_div_done) begin
                           n_state = ST_MUL_UP;
                       end
            ST_MUL_UP: n_state = ST_MUL_DN;
            ST_MUL_DN: n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_dctl.start = (r_state == ST_SUM) && !w_fill;
    assign w_dctl.busy  = (r_state == ST_DIV);

    mabs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dctl),
        .i_dividend (w_nsum),
        .i_divisor  (w_win),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // shared band multiplier: operand times (65536 +/- strip)
    logic [SUM_W-1:0]    w_mx;
    logic [STRIP_W:0]    w_mf;
    logic [SUM_W+16:0]   w_prod;
    logic [SUM_W:0]      w_shr;
    logic [PRICE_W-1:0]  w_sat;

    assign w_mx   = (r_state == ST_MUL_DN && w_fill) ? SUM_W'(r_price) : r_avg;
    assign w_mf   = (r_state == ST_MUL_UP) ? (17'h10000 + 17'(r_strip))
                                           : (17'h10000 - 17'(r_strip));
    assign w_prod = 57'(w_mx) * 57'(w_mf);
    assign w_shr  = w_prod[SUM_W+16:16];
    assign w_sat  = (w_shr > 41'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_shr[PRICE_W-1:0];

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ser   <= SER_W'(i_series_index);
                r_ser6  <= i_series_index;
                r_price <= i_close_price;
            end
            ST_READ: begin
                r_n    <= r_vld[r_ser] ? r_cnt_m[r_ser] : '0;
                r_sum  <= r_vld[r_ser] ? r_sum_m[r_ser] : '0;
                r_ref  <= r_vld[r_ser] ? r_ref_m[r_ser] : '0;
                r_sold <= r_vld[r_ser] && r_sold_m[r_ser];
                r_pos  <= (r_vld[r_ser] && 13'(r_pos_m[r_ser]) < w_win)
                          ? {1'b0, r_pos_m[r_ser]} : '0;
            end
            ST_SUM:    r_sum <= w_nsum;
            ST_DIV:    r_avg <= w_quo;
            ST_MUL_UP: r_up  <= w_sat;
            ST_MUL_DN: r_dn  <= w_sat;
            ST_DECIDE: begin
                if (w_fill) begin
                    r_ref <= r_dn;
                end else if (13'(r_n) == w_win) begin
                    r_sold <= SUM_W'(r_price) <= r_avg;
                    r_ref  <= (SUM_W'(r_price) <= r_avg) ? r_up : r_dn;
                end else if (r_sold) begin
                    if (r_price > r_ref) begin
                        r_sold <= 1'b0;
                        r_ref  <= r_dn;
                    end else if (r_up < r_ref) begin
                        r_ref <= r_up;
                    end
                end else begin
                    if (r_price < r_ref) begin
                        r_sold <= 1'b1;
                        r_ref  <= r_up;
                    end else if (r_dn > r_ref) begin
                        r_ref <= r_dn;
                    end
                end
            end
            default: ;
        endcase
    end

    // ring memory: read oldest, write newest
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_old <= r_ring[{r_ser, ((r_vld[r_ser] && 13'(r_pos_m[r_ser]) < w_win)
                                     ? r_pos_m[r_ser] : POS_W'(0))}];
        end
        if (r_state == ST_WRITE) begin
            r_ring[w_slot] <= r_price;
        end
    end

    // per-series write-back
    logic [POS_W:0] w_npos;
    assign w_npos = (13'(r_pos + 1'b1) >= w_win) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == ST_WRITE) begin
            r_vld[r_ser] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_sum_m[r_ser]  <= r_sum;
            r_ref_m[r_ser]  <= r_ref;
            r_sold_m[r_ser] <= r_sold;
            r_pos_m[r_ser]  <= w_npos[POS_W-1:0];
            r_cnt_m[r_ser]  <= (13'(r_n) <= w_win) ? r_n + 1'b1 : r_n;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == ST_OUT) begin
            r_ovld <= 1'b1;
        end else if (!i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            r_oref  <= r_ref;
            r_osold <= r_sold;
            r_oser  <= r_ser6;
        end
    end

    assign o_valid           = r_ovld;
    assign o_reference_level = r_oref;
    assign o_sold_mode       = r_osold;
    assign o_series_echo     = r_oser;

endmodule

>>> sv/mabs_divider.sv
// ----------------------------------------------------------------------------
// mabs_divider: restoring divider, one quotient bit per cycle
// Divides a 40-bit sum by the window length; quotient fits 40 bits.
// ----------------------------------------------------------------------------
module mabs_divider
    import mabs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_ctl            i_ctl,
    input  logic [SUM_W-1:0]    i_dividend,
    input  logic [WDAY_W+3:0]   i_divisor,
    output logic [SUM_W-1:0]    o_quotient,
    output logic                o_done
);

    logic [SUM_W-1:0]    r_quo;
    logic [WDAY_W+4:0]   r_rem;
    logic [5:0]          r_cnt;
    logic                r_run;
    logic [WDAY_W+4:0]   w_trial;

    assign w_trial = {r_rem[WDAY_W+3:0], r_quo[SUM_W-1]};

    // shift one dividend bit in, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
            r_cnt <= 6'(SUM_W);
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                r_rem <= w_trial - {1'b0, i_divisor};
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = i_ctl.busy && !r_run && !i_ctl.start;

endmodule

>>> sv/mabs_checker.sv
// ----------------------------------------------------------------------------
// mabs_checker: port-level checks for the trailing band block
// Watches handshakes and the one-beat-in-flight behavior.
// ----------------------------------------------------------------------------
module mabs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [5:0] o_series_echo,
    input logic       pready
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_series_echo))
        else $error("result beat dropped while stalled");

    // no input accepted while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // after an accepted beat, the input is closed or no result is valid
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall || !o_valid)
        else $error("input not closed after accept");

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind moving_average_band_signal mabs_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_series_echo (o_series_echo),
    .pready        (pready)
);
